// ===== hw/rtl/lhash_pkg.sv =====
// Shared types and constants for the linear-probing hash table.
// Used by linear_probe_hash_table; no dependencies.
package lhash_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_W       = 4;
    localparam int WORD_W      = 1 + KEY_W + VAL_W;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_W-1:0] MAX_ITEMS_RST = 4'd8;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_DRD,
        S_DCHK,
        S_FIN
    } state_t;

endpackage

// ===== hw/rtl/lhash_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lhash_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Linear-probing key/value hash table: top level with control sequencer.
// Depends on lhash_pkg and lhash_ram.
//
// One operation (insert/update, delete, lookup) is taken at a time. The home
// slot (key mod SLOTS) comes from a registered reciprocal multiply and a
// subtract. Each probe is then a read and a check on the single slot memory,
// so a lookup or insert runs from one accept to the next through the accept,
// the home slot, the probes and the load of the result register. A delete
// also pulls every later entry of the cluster and re-places it: per moved
// entry a read, the home computation and the probes, plus a read and check of
// the slot that ends the cluster. An unread result holds the next one back,
// and with it the input. After reset the block clears the occupancy bit of
// every slot before it accepts an item; configuration writes are taken
// throughout.
module linear_probe_hash_table #(
    parameter int SLOTS = lhash_pkg::SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mode[1:0], key[32:2], value[64:33], zero fill
    input  logic [lhash_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found[0], value_out[32:1], status[35:33], item_count[40:36], zero fill
    output logic [lhash_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lhash_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IW   = $clog2(SLOTS);
    localparam int NW   = $clog2(SLOTS + 1);
    localparam int CMPW = (NW > lhash_pkg::CFG_W) ? NW : lhash_pkg::CFG_W;
    localparam int KW   = lhash_pkg::KEY_W;
    localparam int VW   = lhash_pkg::VAL_W;
    localparam int WW   = lhash_pkg::WORD_W;
    localparam int RW   = 32;
    localparam int PW   = KW + RW;
    // ceil(2^(KW+IW) / SLOTS): exact quotient for every key below 2^KW
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << (KW + IW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];

    lhash_pkg::state_t state_reg, state_next;

    logic [IW-1:0]                    idx_reg, idx_next;
    logic [NW-1:0]                    n_reg, n_next;
    logic [IW-1:0]                    del_idx_reg, del_idx_next;
    logic [NW-1:0]                    del_n_reg, del_n_next;
    logic [NW-1:0]                    items_reg, items_next;
    logic [lhash_pkg::CFG_W-1:0]      max_reg, max_next;
    logic                             placing_reg, placing_next;
    logic                             mod_cnt_reg, mod_cnt_next;
    logic [PW-1:0]                    mod_prod_reg, mod_prod_next;
    logic [KW-1:0]                    mod_key_reg, mod_key_next;
    logic [lhash_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [KW-1:0]                    key_reg, key_next;
    logic [VW-1:0]                    val_reg, val_next;
    logic [KW-1:0]                    re_key_reg, re_key_next;
    logic [VW-1:0]                    re_val_reg, re_val_next;
    logic                             res_found_reg, res_found_next;
    logic [VW-1:0]                    res_vout_reg, res_vout_next;
    logic [lhash_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_found_reg, out_found_next;
    logic [VW-1:0]                    out_vout_reg, out_vout_next;
    logic [lhash_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [lhash_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    logic          rd_occ;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic [IW-1:0] idx_inc;
    logic [IW-1:0] del_idx_inc;
    logic [IW-1:0] mod_q_lo;
    logic [IW-1:0] mod_step;
    logic          at_limit;

    lhash_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_occ = ram_rdata[WW-1];
    assign rd_key = ram_rdata[VW +: KW];
    assign rd_val = ram_rdata[VW-1:0];

    assign idx_inc     = (idx_reg == IW'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign del_idx_inc = (del_idx_reg == IW'(SLOTS - 1)) ? '0 : del_idx_reg + 1'b1;

    assign at_limit = (CMPW'(items_reg) >= CMPW'(max_reg)) || (items_reg == NW'(SLOTS));

    // Remainder is below 2^IW, so only the low bits of key - q*SLOTS matter.
    assign mod_q_lo = mod_prod_reg[KW + IW +: IW];
    assign mod_step = mod_key_reg[IW-1:0] - IW'(mod_q_lo * IW'(SLOTS));

    assign s_tready  = (state_reg == lhash_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_count_reg, out_status_reg, out_vout_reg, out_found_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhash_pkg::S_CLEAR;
            idx_reg       <= '0;
            items_reg     <= '0;
            max_reg       <= lhash_pkg::MAX_ITEMS_RST;
            placing_reg   <= 1'b0;
            mod_cnt_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            items_reg     <= items_next;
            max_reg       <= max_next;
            placing_reg   <= placing_next;
            mod_cnt_reg   <= mod_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        del_idx_reg    <= del_idx_next;
        del_n_reg      <= del_n_next;
        mod_prod_reg   <= mod_prod_next;
        mod_key_reg    <= mod_key_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        re_key_reg     <= re_key_next;
        re_val_reg     <= re_val_next;
        res_found_reg  <= res_found_next;
        res_vout_reg   <= res_vout_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_vout_reg   <= out_vout_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        del_idx_next    = del_idx_reg;
        del_n_next      = del_n_reg;
        items_next      = items_reg;
        max_next        = max_reg;
        placing_next    = placing_reg;
        mod_cnt_next    = mod_cnt_reg;
        mod_prod_next   = mod_prod_reg;
        mod_key_next    = mod_key_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        re_key_next     = re_key_reg;
        re_val_next     = re_val_reg;
        res_found_next  = res_found_reg;
        res_vout_next   = res_vout_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_vout_next   = out_vout_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {1'b1, key_reg, val_reg};
        ram_raddr       = idx_reg;

        if (cfg_valid)
        begin
            max_next = cfg_data;
        end
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lhash_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                idx_next  = idx_inc;
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    state_next = lhash_pkg::S_IDLE;
                end
            end
            lhash_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next    = s_tdata[1:0];
                    key_next     = s_tdata[32:2];
                    val_next     = s_tdata[64:33];
                    mod_key_next = s_tdata[32:2];
                    mod_cnt_next = 1'b0;
                    placing_next = 1'b0;
                    state_next   = lhash_pkg::S_MOD;
                end
            end
            lhash_pkg::S_MOD:
            begin
                if (!mod_cnt_reg)
                begin
                    mod_prod_next = PW'(mod_key_reg) * PW'(RECIP);
                    mod_cnt_next  = 1'b1;
                end
                else
                begin
                    idx_next   = mod_step;
                    n_next     = '0;
                    state_next = lhash_pkg::S_RD;
                end
            end
            lhash_pkg::S_RD:
            begin
                state_next = lhash_pkg::S_CHK;
            end
            lhash_pkg::S_CHK:
            begin
                if (placing_reg)
                begin
                    if (!rd_occ)
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = {1'b1, re_key_reg, re_val_reg};
                        placing_next = 1'b0;
                        del_idx_next = del_idx_inc;
                        del_n_next   = del_n_reg + 1'b1;
                        state_next   = lhash_pkg::S_DRD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = lhash_pkg::S_RD;
                    end
                end
                else if (rd_occ && rd_key != key_reg && n_reg != NW'(SLOTS - 1))
                begin
                    idx_next   = idx_inc;
                    n_next     = n_reg + 1'b1;
                    state_next = lhash_pkg::S_RD;
                end
                else
                begin
                    // Probe run ended: hit, empty slot, or whole table walked.
                    res_found_next  = rd_occ && rd_key == key_reg;
                    res_vout_next   = '0;
                    res_status_next = lhash_pkg::ST_MISSING;
                    state_next      = lhash_pkg::S_FIN;
                    case (mode_reg)
                        lhash_pkg::MODE_INSERT:
                        begin
                            if (rd_occ && rd_key == key_reg)
                            begin
                                ram_we          = 1'b1;
                                res_status_next = lhash_pkg::ST_UPDATED;
                            end
                            else if (at_limit || rd_occ)
                            begin
                                res_status_next = lhash_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                items_next      = items_reg + 1'b1;
                                res_status_next = lhash_pkg::ST_NEW;
                            end
                        end
                        lhash_pkg::MODE_DELETE:
                        begin
                            if (rd_occ && rd_key == key_reg)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = {1'b0, rd_key, rd_val};
                                if (items_reg != '0)
                                begin
                                    items_next = items_reg - 1'b1;
                                end
                                res_status_next = lhash_pkg::ST_DELETED;
                                del_idx_next    = idx_inc;
                                del_n_next      = NW'(1);
                                state_next      = lhash_pkg::S_DRD;
                            end
                        end
                        lhash_pkg::MODE_LOOKUP:
                        begin
                            if (rd_occ && rd_key == key_reg)
                            begin
                                res_vout_next   = rd_val;
                                res_status_next = lhash_pkg::ST_NEW;
                            end
                            else
                            begin
                                res_vout_next = val_reg;
                            end
                        end
                        default:
                        begin
                            res_status_next = lhash_pkg::ST_MISSING;
                        end
                    endcase
                end
            end
            lhash_pkg::S_DRD:
            begin
                ram_raddr = del_idx_reg;
                if (del_n_reg == NW'(SLOTS))
                begin
                    state_next = lhash_pkg::S_FIN;
                end
                else
                begin
                    state_next = lhash_pkg::S_DCHK;
                end
            end
            lhash_pkg::S_DCHK:
            begin
                ram_raddr = del_idx_reg;
                if (!rd_occ)
                begin
                    state_next = lhash_pkg::S_FIN;
                end
                else
                begin
                    // Lift the entry out, then re-place it from its home slot.
                    ram_we       = 1'b1;
                    ram_waddr    = del_idx_reg;
                    ram_wdata    = {1'b0, rd_key, rd_val};
                    re_key_next  = rd_key;
                    re_val_next  = rd_val;
                    mod_key_next = rd_key;
                    mod_cnt_next = 1'b0;
                    placing_next = 1'b1;
                    state_next   = lhash_pkg::S_MOD;
                end
            end
            lhash_pkg::S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_vout_next   = res_vout_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = lhash_pkg::COUNT_OUT_W'(items_reg);
                    state_next      = lhash_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lhash_pkg::S_IDLE;
            end
        endcase
    end

endmodule
